// ===== hw/rtl/ip_address_lookup2_hash_defines.svh =====
// Assertion macros for the IP address lookup2 hash block.
// Used by files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef IP_ADDRESS_LOOKUP2_HASH_DEFINES_SVH
`define IP_ADDRESS_LOOKUP2_HASH_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define IPLH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iplh: implication check failed");
// Next-cycle implication, checked out of reset
`define IPLH_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iplh: next-cycle check failed");
`else
`define IPLH_ASSERT_IMP(lbl, ante, cons)
`define IPLH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/iplh_pkg.sv =====
// Shared types and constants for the IP address lookup2 hash block.
// No dependencies; used by the interfaces, the mixing pipe and the top level.
package iplh_pkg;

  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned BUCKET_W = 8;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned HASH_BITS = 8;
  localparam int unsigned MIX_ROWS = 9;

  localparam logic [WORD_W-1:0] GOLDEN = 32'h9e3779b9;
  localparam logic [WORD_W-1:0] LEN_V4 = 32'd4;
  localparam logic [WORD_W-1:0] LEN_V6 = 32'd16;

  // ip_mode register codes; any other code hashes to zero
  localparam logic [MODE_W-1:0] MODE_V4 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_V6 = 2'd1;

  localparam logic [WORD_W-1:0] HASH_MASK = (HASH_BITS >= WORD_W) ? '1 :
                                            WORD_W'((64'd1 << HASH_BITS) - 64'd1);
  localparam logic [BUCKET_W-1:0] BUCKET_MASK = HASH_MASK[BUCKET_W-1:0];

  // Hash state carried down the pipe: a/b/c words, the word added at the
  // second pass, and the key kind
  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic [WORD_W-1:0] side;
    logic              v4;
    logic              v6;
  } iplh_hs_t;

  // Four bytes in network order packed little-endian
  function automatic logic [WORD_W-1:0] le_word(input logic [WORD_W-1:0] be);
    return {be[7:0], be[15:8], be[23:16], be[31:24]};
  endfunction

endpackage

// ===== hw/rtl/iplh_ifs.sv =====
// Valid/ready channel interfaces for the IP address lookup2 hash block.
// Depends on iplh_pkg for payload widths.
interface iplh_in_if;
  logic                        valid;
  logic                        ready;
  logic [iplh_pkg::ADDR_W-1:0] addr_upper;
  logic [iplh_pkg::ADDR_W-1:0] addr_lower;
  modport source (output valid, addr_upper, addr_lower, input ready);
  modport sink   (input valid, addr_upper, addr_lower, output ready);
endinterface

interface iplh_out_if;
  logic                          valid;
  logic                          ready;
  logic [iplh_pkg::BUCKET_W-1:0] bucket;
  modport source (output valid, bucket, input ready);
  modport sink   (input valid, bucket, output ready);
endinterface

interface iplh_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [iplh_pkg::MODE_W-1:0] ip_mode;
  modport source (output valid, ip_mode, input ready);
  modport sink   (input valid, ip_mode, output ready);
endinterface

// ===== hw/rtl/ip_address_lookup2_hash.sv =====
// Top level of the IP address lookup2 hash block: channels, mode register, I/O regs.
// Depends on iplh_pkg, iplh_ifs, iplh_mix_pipe and ip_address_lookup2_hash_defines.svh.
//
// Hashes one IP address per request into a table bucket (lookup2, initial
// value zero, masked to HASH_BITS). A new request is taken every cycle while
// the result side is not stalled; the bucket passes through one input register,
// 18 mix-row stages (two mixing passes of nine rows, one row per stage) and
// the result register. When the result side stalls the whole pipe holds, and
// input ready drops with it. ip_mode selects IPv4 (four bytes from the top of
// addr_upper), IPv6 (all sixteen bytes), or a zero bucket; it is sampled as
// each request is taken and should be written only while the block is empty.
`include "ip_address_lookup2_hash_defines.svh"

module ip_address_lookup2_hash (
  input  logic       clk,
  input  logic       rst_n,
  iplh_in_if.sink    in_if,
  iplh_out_if.source out_if,
  iplh_cfg_if.sink   cfg_if
);
  import iplh_pkg::*;

  logic [MODE_W-1:0]   mode_r;
  logic                en;
  logic [WORD_W-1:0]   w0, w4, w8, w12;
  iplh_hs_t            load_st;
  iplh_hs_t            in_st_r;
  logic                in_vld_r;
  logic                pipe_vld;
  iplh_hs_t            pipe_st;
  logic [BUCKET_W-1:0] bucket_nxt;
  logic [BUCKET_W-1:0] bucket_r;
  logic                out_valid_r;

  // Mode register, always writable
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_V4;
    end else if (cfg_if.valid) begin
      mode_r <= cfg_if.ip_mode;
    end
  end

  // Pipe advances unless a result is waiting and not taken
  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  // Key words, little-endian packing of network-order bytes
  assign w0  = le_word(in_if.addr_upper[63:32]);
  assign w4  = le_word(in_if.addr_upper[31:0]);
  assign w8  = le_word(in_if.addr_lower[63:32]);
  assign w12 = le_word(in_if.addr_lower[31:0]);

  // Initial hash state; IPv4 carries its word to the second pass
  always_comb begin
    load_st.v4 = (mode_r == MODE_V4);
    load_st.v6 = (mode_r == MODE_V6);
    if (load_st.v6) begin
      load_st.a    = GOLDEN + w0;
      load_st.b    = GOLDEN + w4;
      load_st.c    = w8;
      load_st.side = w12;
    end else begin
      load_st.a    = GOLDEN;
      load_st.b    = GOLDEN;
      load_st.c    = '0;
      load_st.side = w0;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (en) begin
      in_vld_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_st_r <= load_st;
    end
  end

  iplh_mix_pipe u_mix_pipe (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_vld_r),
    .in_st   (in_st_r),
    .out_vld (pipe_vld),
    .out_st  (pipe_st)
  );

  // Bucket select and mask
  assign bucket_nxt = (pipe_st.v4 || pipe_st.v6) ?
                      (pipe_st.c[BUCKET_W-1:0] & BUCKET_MASK) : '0;

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= pipe_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bucket_r <= bucket_nxt;
    end
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.bucket = bucket_r;

  // Checks
  `IPLH_ASSERT_IMP(a_empty_after_reset, $past(!rst_n), !out_valid_r && !in_vld_r)
  `IPLH_ASSERT_NXT(a_pipe_to_result, en && pipe_vld, out_valid_r)
  `IPLH_ASSERT_NXT(a_other_mode_zero, en && pipe_vld && !pipe_st.v4 && !pipe_st.v6, bucket_r == '0)
  `IPLH_ASSERT_IMP(a_bucket_masked, out_valid_r, (bucket_r & ~BUCKET_MASK) == '0)
  `IPLH_ASSERT_IMP(a_kind_exclusive, in_vld_r, !(in_st_r.v4 && in_st_r.v6))

endmodule

// ===== hw/rtl/iplh_mix_pipe.sv =====
// Two lookup2 mixing passes, one mix row per pipeline stage.
// Depends on iplh_pkg for the hash state type and constants.
module iplh_mix_pipe (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  iplh_pkg::iplh_hs_t in_st,
  output logic               out_vld,
  output iplh_pkg::iplh_hs_t out_st
);
  import iplh_pkg::*;

  localparam int unsigned STAGES = 2 * MIX_ROWS;
  localparam logic [4:0] MIX_SHIFT [MIX_ROWS] =
    '{5'd13, 5'd8, 5'd13, 5'd12, 5'd16, 5'd5, 5'd3, 5'd10, 5'd15};

  // One row of the mix: x = (x - y - z) ^ shift(z), rotating over a, b, c
  function automatic iplh_hs_t mix_row(input iplh_hs_t s, input logic [3:0] row);
    iplh_hs_t   r;
    logic [4:0] sh;
    r  = s;
    sh = MIX_SHIFT[row];
    case (row)
      4'd0, 4'd3, 4'd6: r.a = (s.a - s.b - s.c) ^ (s.c >> sh);
      4'd1, 4'd4, 4'd7: r.b = (s.b - s.c - s.a) ^ (s.a << sh);
      default:          r.c = (s.c - s.a - s.b) ^ (s.b >> sh);
    endcase
    return r;
  endfunction

  // Between passes: IPv6 adds the length and the last word; IPv4 starts
  // fresh here, so its single mix is the second pass
  function automatic iplh_hs_t inject(input iplh_hs_t s);
    iplh_hs_t r;
    r = s;
    if (s.v6) begin
      r.a = s.a + s.side;
      r.c = s.c + LEN_V6;
    end else begin
      r.a = GOLDEN + s.side;
      r.b = GOLDEN;
      r.c = LEN_V4;
    end
    return r;
  endfunction

  iplh_hs_t          st_r   [STAGES];
  iplh_hs_t          st_nxt [STAGES];
  logic [STAGES-1:0] vld_r;
  logic [STAGES-1:0] vld_nxt;

  // Stage input select and row logic
  always_comb begin
    st_nxt[0]  = mix_row(in_st, 4'd0);
    vld_nxt[0] = in_vld;
    for (int s = 1; s < STAGES; s++) begin
      if (s == MIX_ROWS) begin
        st_nxt[s] = mix_row(inject(st_r[s-1]), 4'd0);
      end else if (s < MIX_ROWS) begin
        st_nxt[s] = mix_row(st_r[s-1], 4'(s));
      end else begin
        st_nxt[s] = mix_row(st_r[s-1], 4'(s - MIX_ROWS));
      end
      vld_nxt[s] = vld_r[s-1];
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // Hash state payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STAGES; s++) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign out_vld = vld_r[STAGES-1];
  assign out_st  = st_r[STAGES-1];

endmodule

// ===== dv/tb_ip_address_lookup2_hash.sv =====
`timescale 1ns / 100ps
// Testbench for ip_address_lookup2_hash: directed table, then random addresses per mode.
// Depends on iplh_pkg, iplh_ifs and the RTL; predicts each bucket with its own lookup2 model.
module tb_ip_address_lookup2_hash;
  import iplh_pkg::*;

  // Codes that hash to zero
  localparam logic [MODE_W-1:0] MODE_ZERO  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned MAX_PRINTS  = 50;
  localparam int unsigned HASH_BLOCK  = 100;
  localparam int unsigned ZERO_BLOCK  = 25;

  localparam logic [MODE_W-1:0] BLOCK_MODES [6] =
    '{MODE_V4, MODE_V6, MODE_ZERO, MODE_V6, MODE_V4, MODE_SPARE};

  typedef struct packed {
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
  } hash_words_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [ADDR_W-1:0]   upper;
    logic [ADDR_W-1:0]   lower;
    logic                known;
    logic [BUCKET_W-1:0] bucket;
  } addr_row_t;

  // Directed requests; bucket typed in only for the zero-hash modes
  addr_row_t directed_rows [20] = '{
    '{MODE_V4,    64'h0,                64'h0,                1'b0, 8'h00},
    '{MODE_V4,    64'hffff_ffff_ffff_ffff, 64'h0,             1'b0, 8'h00},
    '{MODE_V4,    64'hffff_ffff_0000_0000, 64'hffff_ffff_ffff_ffff, 1'b0, 8'h00},
    '{MODE_V4,    64'h0000_0000_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b0, 8'h00},
    '{MODE_V4,    64'h8000_0000_0000_0000, 64'h0,             1'b0, 8'h00},
    '{MODE_V4,    64'h0000_0001_0000_0000, 64'h0,             1'b0, 8'h00},
    '{MODE_V6,    64'h0,                64'h0,                1'b0, 8'h00},
    '{MODE_V6,    64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b0, 8'h00},
    '{MODE_V6,    64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b0, 8'h00},
    '{MODE_V6,    64'h8000_0000_0000_0000, 64'h0,             1'b0, 8'h00},
    '{MODE_V6,    64'h0,                64'h0000_0000_0000_0001, 1'b0, 8'h00},
    '{MODE_V6,    64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0, 8'h00},
    '{MODE_V6,    64'hffff_ffff_ffff_ffff, 64'h0,             1'b0, 8'h00},
    '{MODE_ZERO,  64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1, 8'h00},
    '{MODE_ZERO,  64'h0123_4567_89ab_cdef, 64'h89ab_cdef_0123_4567, 1'b1, 8'h00},
    '{MODE_SPARE, 64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1, 8'h00},
    '{MODE_SPARE, 64'h0,                64'h0,                1'b1, 8'h00},
    '{MODE_V4,    64'hc0a8_0001_0000_0000, 64'h0,             1'b0, 8'h00},
    '{MODE_V6,    64'h2001_0db8_0000_0000, 64'h0000_0000_0000_0001, 1'b0, 8'h00},
    '{MODE_V4,    64'h0a00_0001_1234_5678, 64'hdead_beef_cafe_f00d, 1'b0, 8'h00}
  };

  logic clk;
  logic rst_n;

  iplh_in_if  in_ch ();
  iplh_out_if out_ch ();
  iplh_cfg_if cfg_ch ();

  ip_address_lookup2_hash dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  logic [BUCKET_W-1:0] pending_buckets [$];
  logic [MODE_W-1:0]   cur_mode;
  logic                row_known;
  logic [BUCKET_W-1:0] row_bucket;
  int unsigned         send_idle_pct;
  int unsigned         take_idle_pct;
  int unsigned         mismatch_count;
  int unsigned         quiet_cycles;

  // Four key bytes from network order, first byte lands in the low byte
  function automatic logic [WORD_W-1:0] key_word(logic [2*ADDR_W-1:0] key,
                                                 int unsigned first);
    logic [WORD_W-1:0] w;
    for (int k = 0; k < 4; k++) begin
      w[8*k +: 8] = key[2*ADDR_W-1 - 8*(first+k) -: 8];
    end
    return w;
  endfunction

  // One full lookup2 mix of the three words
  function automatic hash_words_t mix_abc(hash_words_t s);
    logic [WORD_W-1:0] a, b, c;
    a = s.a;
    b = s.b;
    c = s.c;
    a = (a - b - c) ^ (c >> 13);
    b = (b - c - a) ^ (a << 8);
    c = (c - a - b) ^ (b >> 13);
    a = (a - b - c) ^ (c >> 12);
    b = (b - c - a) ^ (a << 16);
    c = (c - a - b) ^ (b >> 5);
    a = (a - b - c) ^ (c >> 3);
    b = (b - c - a) ^ (a << 10);
    c = (c - a - b) ^ (b >> 15);
    return '{a: a, b: b, c: c};
  endfunction

  // Expected bucket for one address under the given mode
  function automatic logic [BUCKET_W-1:0] lookup2_bucket(logic [MODE_W-1:0] mode,
                                                         logic [ADDR_W-1:0] up,
                                                         logic [ADDR_W-1:0] lo);
    logic [2*ADDR_W-1:0] key;
    hash_words_t         s;
    key = {up, lo};
    s.a = GOLDEN;
    s.b = GOLDEN;
    s.c = '0;
    if (mode == MODE_V4) begin
      s.c += LEN_V4;
      s.a += key_word(key, 0);
      s = mix_abc(s);
    end else if (mode == MODE_V6) begin
      s.a += key_word(key, 0);
      s.b += key_word(key, 4);
      s.c += key_word(key, 8);
      s = mix_abc(s);
      s.c += LEN_V6;
      s.a += key_word(key, 12);
      s = mix_abc(s);
    end else begin
      s.c = '0;
    end
    return s.c[BUCKET_W-1:0] & BUCKET_MASK;
  endfunction

  // Mostly random halves, with some all-zero, all-one and single-bit patterns
  function automatic logic [ADDR_W-1:0] rand_half();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      3: return ~(64'd1 << $urandom_range(63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Offer one request; returns at the edge where it is taken
  task automatic send_request(input logic [ADDR_W-1:0] up, input logic [ADDR_W-1:0] lo,
                              input logic known, input logic [BUCKET_W-1:0] bucket);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    row_known  = known;
    row_bucket = bucket;
    in_ch.valid      <= 1'b1;
    in_ch.addr_upper <= up;
    in_ch.addr_lower <= lo;
    @(negedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  // Hold off requests until every pending bucket has come back
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending_buckets.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_mode(input logic [MODE_W-1:0] m);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.ip_mode <= m;
    @(negedge clk);
    while (!cfg_ch.ready) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cur_mode = m;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: random stalls
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  // Mid-cycle sampling: check results, log requests, watchdog
  always @(negedge clk) begin
    logic [BUCKET_W-1:0] want;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_buckets.size() == 0) begin
        report_mismatch($sformatf("bucket %0h with no request pending", out_ch.bucket));
      end else begin
        want = pending_buckets.pop_front();
        if (out_ch.bucket !== want)
          report_mismatch($sformatf("bucket got %0h want %0h", out_ch.bucket, want));
      end
    end
    if (in_ch.valid && in_ch.ready)
      pending_buckets.push_back(row_known ? row_bucket :
                                lookup2_bucket(cur_mode, in_ch.addr_upper, in_ch.addr_lower));
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n_items;
    mismatch_count = 0;
    quiet_cycles   = 0;
    cur_mode       = MODE_V4;
    row_known      = 1'b0;
    row_bucket     = '0;
    send_idle_pct  = 11;
    take_idle_pct  = 79;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.addr_upper <= '0;
    in_ch.addr_lower <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.ip_mode   <= MODE_V4;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; first rows run on the reset mode
    foreach (directed_rows[i]) begin
      if (directed_rows[i].mode != cur_mode) begin
        wait_drained();
        write_mode(directed_rows[i].mode);
      end
      send_request(directed_rows[i].upper, directed_rows[i].lower,
                   directed_rows[i].known, directed_rows[i].bucket);
    end

    // Random blocks under three stall mixes
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 11; take_idle_pct = 79; end
        1: begin send_idle_pct = 79; take_idle_pct = 11; end
        default: begin send_idle_pct = 0; take_idle_pct = 0; end
      endcase
      foreach (BLOCK_MODES[blk]) begin
        if (BLOCK_MODES[blk] != cur_mode) begin
          wait_drained();
          write_mode(BLOCK_MODES[blk]);
        end
        n_items = (cur_mode == MODE_V4 || cur_mode == MODE_V6) ? HASH_BLOCK : ZERO_BLOCK;
        for (int k = 0; k < n_items; k++) begin
          // occasional full drain in the middle of a block
          if ($urandom_range(149) == 0) wait_drained();
          send_request(rand_half(), rand_half(), 1'b0, '0);
        end
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_buckets.size() != 0)
      report_mismatch($sformatf("%0d buckets never returned", pending_buckets.size()));
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/iplh_pkg.sv
hw/rtl/iplh_ifs.sv
hw/rtl/iplh_mix_pipe.sv
hw/rtl/ip_address_lookup2_hash.sv
dv/tb_ip_address_lookup2_hash.sv
